>>> sv/mse_pkg.sv
// mse_pkg: shared types and constants for the merge sort engine
// no dependencies; used by the interfaces, the sort cell and the top level

package mse_pkg;

	localparam int unsigned MSE_CAPACITY = 64;
	localparam int unsigned VAL_W        = 32;

	typedef struct packed {
		logic                    vld;
		logic signed [VAL_W-1:0] val;
	} tok_t;

	typedef struct packed {
		logic shift;
		logic desc;
	} cell_ctrl_t;

	typedef enum logic [2:0] {
		ST_LOAD   = 3'b001,
		ST_SETTLE = 3'b010,
		ST_EMIT   = 3'b100
	} state_t;

endpackage

>>> sv/mse_ifs.sv
// mse_ifs: valid/ready channel interfaces for input, output and configuration
// depends on mse_pkg

interface mse_in_if
	import mse_pkg::*;
();
	logic                    valid;
	logic                    ready;
	logic signed [VAL_W-1:0] value_in;
	logic                    last_in;

	modport source (output valid, value_in, last_in, input ready);
	modport sink   (input valid, value_in, last_in, output ready);
endinterface

interface mse_out_if
	import mse_pkg::*;
();
	logic                    valid;
	logic                    ready;
	logic signed [VAL_W-1:0] value_out;
	logic                    last_out;
	logic                    overflow;

	modport source (output valid, value_out, last_out, overflow, input ready);
	modport sink   (input valid, value_out, last_out, overflow, output ready);
endinterface

interface mse_cfg_if;
	logic valid;
	logic ready;
	logic descending;

	modport source (output valid, descending, input ready);
	modport sink   (input valid, descending, output ready);
endinterface

>>> sv/merge_sort_engine.sv
// merge_sort_engine: a set of values loads at one transfer per cycle; values past
// CAPACITY are dropped and set overflow. The set then settles while the last tokens
// ripple down the cell row, then emits from the head cell one result per cycle while
// snk.ready is high; the settle time is set by the length of the insertion cell row
// arst_n clears the fill count, overflow flag, order register and all cell valid bits
// depends on mse_pkg, mse_ifs and mse_cell

module merge_sort_engine
	import mse_pkg::*;
#(
	parameter int unsigned CAPACITY = MSE_CAPACITY
) (
	input  logic      clk,
	input  logic      arst_n,
	mse_in_if.sink    src,
	mse_out_if.source snk,
	mse_cfg_if.sink   cfg
);

	localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

	state_t           state_q;
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] set_q;
	logic             drop_q;
	logic             desc_q;

	logic       in_xfer;
	logic       out_xfer;
	logic       room;
	cell_ctrl_t ctrl;
	tok_t       tok_w [CAPACITY];
	tok_t       cur_w [CAPACITY];
	tok_t       tail;

	assign in_xfer  = src.valid && src.ready;
	assign out_xfer = snk.valid && snk.ready;
	assign room     = (cnt_q != CNT_W'(CAPACITY));

	assign src.ready = (state_q == ST_LOAD);
	assign cfg.ready = 1'b1;

	assign ctrl.shift = out_xfer;
	assign ctrl.desc  = desc_q;

	assign tok_w[0].vld = in_xfer && room;
	assign tok_w[0].val = src.value_in;
	assign tail         = '0;

	genvar i;
	generate
		for (i = 0; i < CAPACITY; i++) begin : g_cell
			if (i < CAPACITY - 1) begin : g_mid
				mse_cell u_cell (
					.clk    (clk),
					.arst_n (arst_n),
					.ctrl   (ctrl),
					.tok_i  (tok_w[i]),
					.tok_o  (tok_w[i+1]),
					.nxt_i  (cur_w[i+1]),
					.cur_o  (cur_w[i])
				);
			end else begin : g_end
				mse_cell u_cell (
					.clk    (clk),
					.arst_n (arst_n),
					.ctrl   (ctrl),
					.tok_i  (tok_w[i]),
					.tok_o  (),
					.nxt_i  (tail),
					.cur_o  (cur_w[i])
				);
			end
		end
	endgenerate

	assign snk.valid     = (state_q == ST_EMIT);
	assign snk.value_out = cur_w[0].val;
	assign snk.last_out  = (cnt_q == CNT_W'(1));
	assign snk.overflow  = drop_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			desc_q <= 1'b0;
		end else if (cfg.valid && cfg.ready) begin
			desc_q <= cfg.descending;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			cnt_q   <= '0;
			set_q   <= '0;
			drop_q  <= 1'b0;
		end else begin
			case (state_q)
				ST_LOAD: begin
					if (in_xfer) begin
						if (room) begin
							cnt_q <= cnt_q + CNT_W'(1);
						end else begin
							drop_q <= 1'b1;
						end
						if (src.last_in) begin
							state_q <= ST_SETTLE;
							set_q   <= CNT_W'(CAPACITY - 1);
						end
					end
				end
				ST_SETTLE: begin
					if (set_q == '0) begin
						state_q <= ST_EMIT;
					end else begin
						set_q <= set_q - CNT_W'(1);
					end
				end
				ST_EMIT: begin
					if (out_xfer) begin
						cnt_q <= cnt_q - CNT_W'(1);
						if (cnt_q == CNT_W'(1)) begin
							state_q <= ST_LOAD;
							drop_q  <= 1'b0;
						end
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

endmodule

>>> sv/mse_cell.sv
// mse_cell: one insertion cell of the systolic sorter row
// keeps the better of its value and an arriving token, passes the other right;
// on shift it takes nxt_i from its right neighbour; depends on mse_pkg

module mse_cell
	import mse_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  cell_ctrl_t ctrl,
	input  tok_t       tok_i,
	output tok_t       tok_o,
	input  tok_t       nxt_i,
	output tok_t       cur_o
);

	logic                    full_q;
	logic signed [VAL_W-1:0] val_q;
	logic                    tok_vld_q;
	logic signed [VAL_W-1:0] tok_val_q;

	logic                    better;
	logic                    full_d;
	logic signed [VAL_W-1:0] val_d;
	tok_t                    tok_d;

	assign better = ctrl.desc ? (tok_i.val > val_q) : (tok_i.val < val_q);

	always_comb begin
		full_d = full_q;
		val_d  = val_q;
		tok_d  = '0;
		if (ctrl.shift) begin
			full_d = nxt_i.vld;
			val_d  = nxt_i.val;
		end else if (tok_i.vld) begin
			if (!full_q) begin
				full_d = 1'b1;
				val_d  = tok_i.val;
			end else if (better) begin
				val_d     = tok_i.val;
				tok_d.vld = 1'b1;
				tok_d.val = val_q;
			end else begin
				tok_d = tok_i;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_q    <= 1'b0;
			tok_vld_q <= 1'b0;
		end else begin
			full_q    <= full_d;
			tok_vld_q <= tok_d.vld;
		end
	end

	always_ff @(posedge clk) begin
		val_q     <= val_d;
		tok_val_q <= tok_d.val;
	end

	assign tok_o.vld = tok_vld_q;
	assign tok_o.val = tok_val_q;
	assign cur_o.vld = full_q;
	assign cur_o.val = val_q;

endmodule

>>> dv/merge_sort_engine_tb.sv
`timescale 1ns / 100ps
// merge_sort_engine_tb: self-checking testbench for the merge sort engine, with
// directed, random, back-pressure and full-rate set traffic
// depends on mse_pkg, mse_ifs and merge_sort_engine

module merge_sort_engine_tb;
	import mse_pkg::*;

	localparam int unsigned CAP            = MSE_CAPACITY;
	localparam int unsigned WATCHDOG_LIMIT = 2000;
	localparam int unsigned HOLD_CYCLES    = 300;
	localparam int unsigned RANDOM_ITEMS   = 80;
	localparam int          MAX_V          = 32'sh7FFF_FFFF;
	localparam int          MIN_V          = -32'sh7FFF_FFFF - 1;

	typedef struct {
		logic signed [VAL_W-1:0] value;
		logic                    last;
		logic                    overflow;
	} sorted_word_t;

	logic clk = 1'b0;
	logic arst_n;

	mse_in_if  in_ch ();
	mse_out_if out_ch ();
	mse_cfg_if cfg_ch ();

	merge_sort_engine u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.src    (in_ch),
		.snk    (out_ch),
		.cfg    (cfg_ch)
	);

	int           loaded_vals[$];
	bit           set_overflowed = 1'b0;
	bit           order_desc     = 1'b0;
	sorted_word_t sorted_queue[$];
	int           mismatches     = 0;
	int           idle_cycles    = 0;
	int           hold_left      = 0;
	int           stall_left     = 0;
	bit           gaps_on        = 1'b0;
	bit           stalls_on      = 1'b0;
	int           items_sent     = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// keeps the open set sorted as values arrive (past CAP it only flags overflow), emits it on the closing value
	function automatic void load_value(int v, bit last);
		int           j;
		int           t;
		int           n;
		sorted_word_t w;
		if (loaded_vals.size() < CAP) begin
			loaded_vals.push_back(v);
			j = loaded_vals.size() - 1;
			while (j > 0 && loaded_vals[j-1] > loaded_vals[j]) begin
				t = loaded_vals[j-1];
				loaded_vals[j-1] = loaded_vals[j];
				loaded_vals[j] = t;
				j--;
			end
		end else begin
			set_overflowed = 1'b1;
		end
		if (last) begin
			n = loaded_vals.size();
			for (int k = 0; k < n; k++) begin
				w.value = order_desc ? loaded_vals[n-1-k] : loaded_vals[k];
				w.last = (k == n - 1);
				w.overflow = set_overflowed;
				sorted_queue.push_back(w);
			end
			loaded_vals.delete();
			set_overflowed = 1'b0;
		end
	endfunction

	always @(posedge clk) begin
		sorted_word_t exp_w;
		if (arst_n) begin
			if (out_ch.valid && out_ch.ready) begin
				if (sorted_queue.size() == 0) begin
					$error("value_out: expected nothing, actual %0d", out_ch.value_out);
					mismatches++;
				end else begin
					exp_w = sorted_queue.pop_front();
					if (out_ch.value_out !== exp_w.value) begin
						$error("value_out: expected %0d, actual %0d", exp_w.value,
							out_ch.value_out);
						mismatches++;
					end
					if (out_ch.last_out !== exp_w.last) begin
						$error("last_out: expected %0d, actual %0d", exp_w.last,
							out_ch.last_out);
						mismatches++;
					end
					if (out_ch.overflow !== exp_w.overflow) begin
						$error("overflow: expected %0d, actual %0d", exp_w.overflow,
							out_ch.overflow);
						mismatches++;
					end
				end
			end
			if (in_ch.valid && in_ch.ready) begin
				load_value(in_ch.value_in, in_ch.last_in);
			end
			if (cfg_ch.valid && cfg_ch.ready) begin
				order_desc = cfg_ch.descending;
			end
			if ((out_ch.valid && out_ch.ready) || (in_ch.valid && in_ch.ready) ||
				(cfg_ch.valid && cfg_ch.ready)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("tb: failure");
				$finish;
			end
		end
	end

	// result receiver: holds ready low while hold_left runs, else random stall bursts if stalls_on
	initial begin
		out_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				out_ch.ready = 1'b0;
				hold_left--;
			end else if (stall_left > 0) begin
				out_ch.ready = 1'b0;
				stall_left--;
			end else if (stalls_on && $urandom_range(0, 7) == 0) begin
				out_ch.ready = 1'b0;
				stall_left = $urandom_range(0, 18);
			end else begin
				out_ch.ready = 1'b1;
			end
		end
	end

	task automatic send_item(int v, bit last);
		@(negedge clk);
		if (gaps_on && $urandom_range(0, 4) == 0) begin
			in_ch.valid = 1'b0;
			repeat ($urandom_range(1, 19)) @(negedge clk);
		end
		in_ch.valid = 1'b1;
		in_ch.value_in = v;
		in_ch.last_in = last;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		items_sent++;
	endtask

	task automatic send_set(int n);
		int v;
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(0, 5))
				0: begin
					case ($urandom_range(0, 4))
						0: v = MAX_V;
						1: v = MIN_V;
						2: v = 0;
						3: v = -1;
						default: v = 1;
					endcase
				end
				1: v = $urandom_range(0, 16) - 8;
				default: v = $urandom();
			endcase
			send_item(v, i == n - 1);
		end
	endtask

	// waits for every expected result, then lets the block go quiet
	task automatic drain_results();
		@(negedge clk);
		in_ch.valid = 1'b0;
		while (sorted_queue.size() != 0) @(negedge clk);
		repeat (2 * CAP + 8) @(negedge clk);
	endtask

	task automatic write_order(bit desc);
		drain_results();
		cfg_ch.valid = 1'b1;
		cfg_ch.descending = desc;
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
		@(negedge clk);
		cfg_ch.valid = 1'b0;
	endtask

	task automatic test_directed_extremes();
		int edge_vals[7] = '{MAX_V, MIN_V, 0, -1, 1, MAX_V, MIN_V};
		write_order(1'b0);
		foreach (edge_vals[i]) send_item(edge_vals[i], i == 6);
		send_item(MIN_V, 1'b1);
		send_item(5, 1'b0);
		send_item(5, 1'b1);
		write_order(1'b1);
		foreach (edge_vals[i]) send_item(edge_vals[i], i == 6);
		send_item(MAX_V, 1'b1);
		send_item(-3, 1'b0);
		send_item(7, 1'b0);
		send_item(-3, 1'b1);
	endtask

	task automatic test_store_limits();
		write_order(1'b0);
		send_set(CAP);
		write_order(1'b1);
		send_set(CAP + 1);
	endtask

	task automatic test_back_pressure();
		write_order(1'b0);
		hold_left = HOLD_CYCLES;
		send_set(CAP);
		send_set(12);
	endtask

	task automatic test_random_sets();
		int start;
		int pick;
		start = items_sent;
		while (items_sent - start < RANDOM_ITEMS) begin
			if ($urandom_range(0, 3) == 0) begin
				write_order(1'($urandom_range(0, 1)));
			end
			pick = $urandom_range(0, 9);
			if (pick < 7) begin
				send_set($urandom_range(1, 8));
			end else if (pick < 9) begin
				send_set($urandom_range(9, CAP));
			end else begin
				send_set($urandom_range(CAP + 1, CAP + 8));
			end
		end
	endtask

	task automatic test_full_rate();
		gaps_on = 1'b0;
		stalls_on = 1'b0;
		write_order(1'b1);
		send_set(5);
		send_set(1);
		send_set(20);
		write_order(1'b0);
		send_set(3);
		send_set(16);
	endtask

	initial begin
		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.value_in = '0;
		in_ch.last_in = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.descending = 1'b0;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		gaps_on = 1'b1;
		stalls_on = 1'b1;
		test_directed_extremes();
		test_store_limits();
		test_back_pressure();
		test_random_sets();
		test_full_rate();
		drain_results();
		if (mismatches == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule

>>> merge_sort_engine.f
sv/mse_pkg.sv
sv/mse_ifs.sv
sv/mse_cell.sv
sv/merge_sort_engine.sv
dv/merge_sort_engine_tb.sv
